// ===== rtl/core/mersenne_twister_generator_core_defines.svh =====
// Assertion macros for the generator core
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MTG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("generator core check failed");
`define MTG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("generator core check failed");
`else
`define MTG_ASSERT_IMP(lbl, ante, cons)
`define MTG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/mtg_pkg.sv =====
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS);

	localparam logic [31:0] SEED_RESET   = 32'd5489;
	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0]      word_t;

	function automatic word_t twist(input word_t cur, input word_t nxt, input word_t par);
		word_t mix;
		word_t v;
		mix = {cur[31], nxt[30:0]};
		v   = par ^ (mix >> 1);
		if (mix[0])
			v = v ^ TWIST_MATRIX;
		return v;
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		if (y == '0)
			y = 32'd1;
		return y;
	endfunction

endpackage

// ===== rtl/core/mersenne_twister_generator_core.sv =====
// MT19937 uniform 32-bit random word source.
// Request channel s_*: one transfer asks for one word; s_tdata[0] set rebuilds
// the state from the seed register before the word is drawn.
// Result channel m_*: one 32-bit tempered word per request, never zero.
// Seed register: cfg_we/cfg_wdata, taken on any edge with cfg_we high; it only
// changes the seed used by the next reseed request; reset always uses 5489.
// The 624-word state sits in one memory with two registered read ports and
// one write port. Each draw twists exactly one word in place (current word
// held in a register, next and partner words read from the memory), so the
// full twist is spread over 624 draws.
// Flow: a request transfer moves the block from idle to calc, which registers
// the tempered twisted word into the output register once that is free; a new
// request is taken only in idle, after the last word has reached the output
// register. A reseed request first runs the rebuild sweep, one word per cycle
// through the seeding multiplier. Reset: the block rebuilds the state from
// seed 5489 with s_tready low. Stall: a finished word waits in the output
// register; one more request is taken meanwhile, then holds until m_tready.
`include "mersenne_twister_generator_core_defines.svh"

module mersenne_twister_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] reseed, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] random_word
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam logic [1:0] ST_INIT   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_IDLE   = 2'd2;
	localparam logic [1:0] ST_CALC   = 2'd3;

	localparam mtg_pkg::idx_t LAST_IDX = mtg_pkg::IDX_W'(mtg_pkg::STATE_WORDS - 1);

	mtg_pkg::word_t state_mem [mtg_pkg::STATE_WORDS];

	logic [1:0]      st_q;
	logic            draw_q;
	mtg_pkg::idx_t   idx_q;
	mtg_pkg::idx_t   bld_q;
	mtg_pkg::word_t  seed_q;
	mtg_pkg::word_t  prev_q;
	mtg_pkg::word_t  cur_q;
	mtg_pkg::word_t  rd_nxt_q;
	mtg_pkg::word_t  rd_par_q;
	logic            out_valid_q;
	mtg_pkg::word_t  out_data_q;

	mtg_pkg::idx_t   nxt_idx;
	mtg_pkg::idx_t   par_idx;
	logic [mtg_pkg::IDX_W:0] par_sum;
	mtg_pkg::word_t  seed_mix;
	mtg_pkg::word_t  seed_prod;
	mtg_pkg::word_t  bld_word;
	mtg_pkg::word_t  tw_word;
	logic            out_free;
	logic            in_xfer;
	logic            mem_we;
	mtg_pkg::idx_t   mem_wa;
	mtg_pkg::word_t  mem_wd;

	assign nxt_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign par_sum   = {1'b0, idx_q} + (mtg_pkg::IDX_W + 1)'(mtg_pkg::TWIST_OFFSET);
	assign par_idx   = (par_sum >= (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
		? mtg_pkg::IDX_W'(par_sum - (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
		: par_sum[mtg_pkg::IDX_W-1:0];

	assign seed_mix  = prev_q ^ (prev_q >> 30);
	assign seed_prod = mtg_pkg::INIT_MULT * seed_mix;
	assign bld_word  = (bld_q == '0) ? prev_q : seed_prod + 32'(bld_q);
	assign tw_word   = mtg_pkg::twist(cur_q, rd_nxt_q, rd_par_q);

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (st_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = tw_word;
		unique case (st_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = bld_q;
				mem_wd = bld_word;
			end
			ST_CALC: begin
				mem_we = out_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			state_mem[mem_wa] <= mem_wd;
		rd_nxt_q <= state_mem[nxt_idx];
		rd_par_q <= state_mem[par_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			draw_q      <= 1'b0;
			idx_q       <= '0;
			bld_q       <= '0;
			seed_q      <= mtg_pkg::SEED_RESET;
			prev_q      <= mtg_pkg::SEED_RESET;
			cur_q       <= mtg_pkg::SEED_RESET;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_we)
				seed_q <= cfg_wdata;
			if (out_free)
				out_valid_q <= (st_q == ST_CALC);
			unique case (st_q)
				ST_INIT: begin
					prev_q <= bld_word;
					bld_q  <= bld_q + 1'b1;
					if (bld_q == LAST_IDX)
						st_q <= ST_SETTLE;
				end
				ST_SETTLE: begin
					st_q <= draw_q ? ST_CALC : ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tdata[0]) begin
							st_q   <= ST_INIT;
							draw_q <= 1'b1;
							idx_q  <= '0;
							bld_q  <= '0;
							prev_q <= seed_q;
							cur_q  <= seed_q;
						end else begin
							st_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					if (out_free) begin
						out_data_q  <= mtg_pkg::temper(tw_word);
						cur_q       <= rd_nxt_q;
						idx_q       <= nxt_idx;
						draw_q      <= 1'b0;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_INIT;
				end
			endcase
		end
	end

	`MTG_ASSERT_IMP(a_word_nonzero, m_tvalid, m_tdata != '0)
	`MTG_ASSERT_IMP(a_index_range, 1'b1, idx_q <= LAST_IDX)
	`MTG_ASSERT_NXT(a_calc_holds, (st_q == ST_CALC) && out_valid_q && !m_tready, st_q == ST_CALC)
	`MTG_ASSERT_NXT(a_init_to_settle, (st_q == ST_INIT) && (bld_q == LAST_IDX), st_q == ST_SETTLE)

endmodule
